/* src/bf_pkg.sv */
// Shared types, codes and constants of the Blowfish cipher block.
// No dependencies; bf_front, bf_engine and the top level import this package.
`default_nettype none

package bf_pkg;

    // Default values of the top-level parameters.
    localparam int DEF_ROUNDS        = 16;
    localparam int DEF_MAX_KEY_BYTES = 64;

    // Fixed geometry of the S-boxes.
    localparam int S_BOXES     = 4;
    localparam int S_BOX_DEPTH = 256;
    localparam int S_PAIRS     = S_BOXES * S_BOX_DEPTH / 2;

    // Every table word written by the host has each byte XORed with this mask.
    localparam logic [31:0] BYTE_MASK_WORD = 32'h9191_9191;

    // Key length register.
    localparam int              KEY_LEN_W     = 7;
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 7'd64;

    // Command codes on the input channel.
    localparam logic [2:0] CMD_WR_P   = 3'd0;
    localparam logic [2:0] CMD_WR_S   = 3'd1;
    localparam logic [2:0] CMD_WR_K   = 3'd2;
    localparam logic [2:0] CMD_EXPAND = 3'd3;
    localparam logic [2:0] CMD_ENC    = 3'd4;
    localparam logic [2:0] CMD_DEC    = 3'd5;

    // Result kinds on the output channel.
    localparam logic [1:0] KIND_ENC = 2'd0;
    localparam logic [1:0] KIND_DEC = 2'd1;
    localparam logic [1:0] KIND_EXP = 2'd2;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_WR_P,
        OP_WR_S,
        OP_WR_K,
        OP_EXPAND,
        OP_ENC,
        OP_DEC
    } bf_op_t;

    // One classified item as it waits in the queue.
    typedef struct packed {
        bf_op_t      op;
        logic [9:0]  index;
        logic [31:0] word;
        logic [7:0]  key_byte;
        logic [31:0] left_half;
        logic [31:0] right_half;
    } bf_item_t;

    // Queue status seen by the back end and the top level.
    typedef struct packed {
        logic           valid;
        logic [QCW-1:0] count;
    } bf_q_status_t;

endpackage

`default_nettype wire

/* src/bf_if.sv */
// Valid/ready channel interfaces for commands and results.
// No dependencies.
`default_nettype none

interface bf_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [9:0]  index;
    logic [31:0] table_word;
    logic [7:0]  key_byte;
    logic [31:0] left_half;
    logic [31:0] right_half;

    modport source (output valid, command, index, table_word, key_byte, left_half,
                    right_half, input ready);
    modport sink (input valid, command, index, table_word, key_byte, left_half,
                  right_half, output ready);
endinterface

interface bf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_left;
    logic [31:0] out_right;
    logic [1:0]  result_kind;

    modport source (output valid, out_left, out_right, result_kind, input ready);
    modport sink (input valid, out_left, out_right, result_kind, output ready);
endinterface

`default_nettype wire

/* src/blowfish_block_cipher.sv */
// Blowfish cipher engine, top level: command front end, queue and cipher back end.
// Depends on bf_pkg, bf_if, bf_front, bf_engine and bf_ram.
`default_nettype none

// The block takes commands on cmd_ch and returns results on res_ch, both valid/ready
// channels on which a transfer happens at a clock edge with valid and ready high.
// Table writes store each P or S word with every byte XORed with 0x91; key byte writes
// fill the key store, and all three give no result. Writes to a P entry at or beyond
// ROUNDS+2 or to a key position at or beyond MAX_KEY_BYTES are dropped, as are the
// unused command codes. An encrypt or decrypt command gives one block result: the
// back end loads the block and whitens the left half, then runs the rounds, and
// every round reads all four S-box RAMs once through their registered read port.
// An expand command runs the full key schedule in the back end and then gives one
// result with zero halves: it mixes the key bytes into the P-array one per cycle,
// then encrypts and writes back each P-array block and each S-box block in turn,
// the two S words of an S-box block one after the other. A two-entry queue lets
// the front end accept commands while the back end is busy, and the output
// register lets the back end go on while a result waits to be taken. The
// key_length register (cfg_we, cfg_wdata) sets how many key bytes the schedule
// cycles through; zero counts as one and values above MAX_KEY_BYTES count as
// MAX_KEY_BYTES. It resets to 64 and should be written only while the block is
// idle. The tables and key store are not cleared by reset: the host loads them
// before they are used, and reloads the tables before each expansion.

module blowfish_block_cipher #(
    parameter int ROUNDS        = bf_pkg::DEF_ROUNDS,
    parameter int MAX_KEY_BYTES = bf_pkg::DEF_MAX_KEY_BYTES
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [bf_pkg::KEY_LEN_W-1:0] cfg_wdata,
    bf_in_if.sink                             cmd_ch,
    bf_out_if.source                          res_ch
);
    import bf_pkg::*;

    bf_item_t     q_item;
    bf_q_status_t q_status;
    logic         q_pop;

    // Front end: classifies commands and holds them until the back end is free.
    bf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_ch  (cmd_ch),
        .q_item  (q_item),
        .q_status(q_status),
        .q_pop   (q_pop)
    );

    // Back end: tables, key store, round datapath and key schedule.
    bf_engine #(
        .ROUNDS       (ROUNDS),
        .MAX_KEY_BYTES(MAX_KEY_BYTES)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .q_item   (q_item),
        .q_status (q_status),
        .q_pop    (q_pop),
        .res_ch   (res_ch)
    );

    // An expansion result always carries zero halves.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_ch.valid && res_ch.result_kind == KIND_EXP)
            |-> (res_ch.out_left == '0 && res_ch.out_right == '0))
        else $error("expansion result with nonzero halves");

    // The back end takes an item only when the queue holds one.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_status.valid)
        else $error("queue popped while empty");

    // A full queue refuses further transfers.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_status.count == QCW'(QUEUE_DEPTH)) |-> !cmd_ch.ready)
        else $error("command accepted into a full queue");

    // After a pop with no transfer in, the queue is no longer full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !(cmd_ch.valid && cmd_ch.ready)) |=> (q_status.count < QCW'(QUEUE_DEPTH)))
        else $error("queue occupancy did not fall after a pop");

endmodule

`default_nettype wire

/* src/bf_ram.sv */
// Generic simple dual-port RAM with registered read data.
// No dependencies.
`default_nettype none

module bf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/bf_front.sv */
// Front end: accepts commands, classifies them and queues them for the back end.
// Depends on bf_pkg and bf_if.
`default_nettype none

module bf_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    bf_in_if.sink              cmd_ch,
    output bf_pkg::bf_item_t   q_item,
    output bf_pkg::bf_q_status_t q_status,
    input  wire logic          q_pop
);
    import bf_pkg::*;

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    bf_item_t       mem_reg [QUEUE_DEPTH];
    logic [QW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;
    bf_item_t       item;
    logic           keep;
    logic           push;

    // Unknown commands are dropped here and never reach the back end.
    always_comb
    begin
        item.op         = OP_WR_P;
        item.index      = cmd_ch.index;
        item.word       = cmd_ch.table_word ^ BYTE_MASK_WORD;
        item.key_byte   = cmd_ch.key_byte;
        item.left_half  = cmd_ch.left_half;
        item.right_half = cmd_ch.right_half;
        keep            = 1'b1;
        case (cmd_ch.command)
            CMD_WR_P:   item.op = OP_WR_P;
            CMD_WR_S:   item.op = OP_WR_S;
            CMD_WR_K:   item.op = OP_WR_K;
            CMD_EXPAND: item.op = OP_EXPAND;
            CMD_ENC:    item.op = OP_ENC;
            CMD_DEC:    item.op = OP_DEC;
            default:    keep = 1'b0;
        endcase
    end

    assign cmd_ch.ready = (count_reg != QCW'(QUEUE_DEPTH));
    assign push         = cmd_ch.valid && cmd_ch.ready && keep;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QCW'(push) - QCW'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

    assign q_item         = mem_reg[rd_ptr_reg];
    assign q_status.valid = (count_reg != '0);
    assign q_status.count = count_reg;

endmodule

`default_nettype wire

/* src/bf_engine.sv */
// Back end: table and key stores, Feistel round datapath and key schedule sequencer.
// Depends on bf_pkg, bf_if and bf_ram.
`default_nettype none

module bf_engine #(
    parameter int ROUNDS        = bf_pkg::DEF_ROUNDS,
    parameter int MAX_KEY_BYTES = bf_pkg::DEF_MAX_KEY_BYTES
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [bf_pkg::KEY_LEN_W-1:0] cfg_wdata,
    input  bf_pkg::bf_item_t                  q_item,
    input  bf_pkg::bf_q_status_t              q_status,
    output logic                              q_pop,
    bf_out_if.source                          res_ch
);
    import bf_pkg::*;

    localparam int PD       = ROUNDS + 2;
    localparam int PIW      = $clog2(PD);
    localparam int RW       = $clog2(ROUNDS);
    localparam int KW       = $clog2(MAX_KEY_BYTES);
    localparam int NTOT     = 4 * PD;
    localparam int NW       = $clog2(NTOT + 1);
    localparam int P_BLOCKS = PD / 2;
    localparam int BLKS     = P_BLOCKS + S_PAIRS;
    localparam int BW       = $clog2(BLKS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEYMIX,
        ST_START,
        ST_ROUND,
        ST_SW0,
        ST_SW1,
        ST_DONE
    } state_t;

    function automatic logic [PIW-1:0] p_index(input logic [PIW-1:0] k, input logic dec);
        p_index = dec ? (PIW'(ROUNDS + 1) - k) : k;
    endfunction

    state_t               state_reg, state_next;
    logic [31:0]          p_reg [PD];
    logic [31:0]          lx_reg, lx_next;
    logic [31:0]          r_reg, r_next;
    logic [31:0]          hold_l_reg, hold_l_next;
    logic [31:0]          hold_r_reg, hold_r_next;
    logic [RW-1:0]        rnd_reg, rnd_next;
    logic                 dec_reg, dec_next;
    logic                 exp_reg, exp_next;
    logic [BW-1:0]        blk_reg, blk_next;
    logic [NW-1:0]        n_reg, n_next;
    logic [NW-1:0]        kn_reg, kn_next;
    logic                 kv_reg, kv_next;
    logic [KW-1:0]        j_reg, j_next;
    logic [23:0]          acc_reg, acc_next;
    logic [KEY_LEN_W-1:0] len_reg, len_next;
    logic [KEY_LEN_W-1:0] key_length_reg;
    logic [KEY_LEN_W-1:0] eff_len;
    logic                 out_valid_reg, out_valid_next;
    logic [31:0]          out_l_reg, out_l_next;
    logic [31:0]          out_r_reg, out_r_next;
    logic [1:0]           out_kind_reg, out_kind_next;

    logic [S_BOXES-1:0]   s_we;
    logic [7:0]           s_waddr;
    logic [31:0]          s_wdata;
    logic [31:0]          s_rdata [S_BOXES];
    logic                 k_we;
    logic [KW-1:0]        k_waddr;
    logic [7:0]           k_wdata;
    logic [7:0]           k_rdata;
    logic                 p_we0, p_we1;
    logic [PIW-1:0]       p_idx0, p_idx1, p_rd_idx;
    logic [31:0]          p_d0, p_d1, p_sel;
    logic [31:0]          f_val, new_l, res_l, res_r;
    logic                 out_free;
    logic [8:0]           s_pair;

    // One RAM per S-box so that a round reads all four in the same cycle.
    for (genvar g = 0; g < S_BOXES; g++)
    begin : g_sbox
        bf_ram #(
            .WIDTH(32),
            .DEPTH(S_BOX_DEPTH)
        ) u_sbox (
            .clk  (clk),
            .we   (s_we[g]),
            .waddr(s_waddr),
            .wdata(s_wdata),
            .raddr(lx_next[31-8*g -: 8]),
            .rdata(s_rdata[g])
        );
    end

    bf_ram #(
        .WIDTH(8),
        .DEPTH(MAX_KEY_BYTES)
    ) u_key (
        .clk  (clk),
        .we   (k_we),
        .waddr(k_waddr),
        .wdata(k_wdata),
        .raddr(j_reg),
        .rdata(k_rdata)
    );

    assign eff_len = (key_length_reg == '0) ? KEY_LEN_W'(1) :
                     (key_length_reg > KEY_LEN_W'(MAX_KEY_BYTES)) ?
                     KEY_LEN_W'(MAX_KEY_BYTES) : key_length_reg;

    assign p_sel    = p_reg[p_rd_idx];
    assign f_val    = ((s_rdata[0] + s_rdata[1]) ^ s_rdata[2]) + s_rdata[3];
    assign new_l    = r_reg ^ f_val;
    assign res_l    = lx_reg ^ (dec_reg ? p_reg[0] : p_reg[ROUNDS + 1]);
    assign res_r    = new_l ^ (dec_reg ? p_reg[1] : p_reg[ROUNDS]);
    assign out_free = !out_valid_reg || res_ch.ready;
    assign s_pair   = 9'(blk_reg - BW'(P_BLOCKS));

    always_comb
    begin
        state_next     = state_reg;
        lx_next        = lx_reg;
        r_next         = r_reg;
        hold_l_next    = hold_l_reg;
        hold_r_next    = hold_r_reg;
        rnd_next       = rnd_reg;
        dec_next       = dec_reg;
        exp_next       = exp_reg;
        blk_next       = blk_reg;
        n_next         = n_reg;
        kn_next        = kn_reg;
        kv_next        = 1'b0;
        j_next         = j_reg;
        acc_next       = acc_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg && !res_ch.ready;
        out_l_next     = out_l_reg;
        out_r_next     = out_r_reg;
        out_kind_next  = out_kind_reg;
        q_pop          = 1'b0;
        s_we           = '0;
        s_waddr        = '0;
        s_wdata        = '0;
        k_we           = 1'b0;
        k_waddr        = '0;
        k_wdata        = '0;
        p_we0          = 1'b0;
        p_idx0         = '0;
        p_d0           = '0;
        p_we1          = 1'b0;
        p_idx1         = '0;
        p_d1           = '0;
        p_rd_idx       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_status.valid)
                begin
                    q_pop = 1'b1;
                    case (q_item.op)
                        OP_WR_P:
                        begin
                            if (q_item.index < 10'(PD))
                            begin
                                p_we0  = 1'b1;
                                p_idx0 = PIW'(q_item.index);
                                p_d0   = q_item.word;
                            end
                        end
                        OP_WR_S:
                        begin
                            s_we[q_item.index[9:8]] = 1'b1;
                            s_waddr = q_item.index[7:0];
                            s_wdata = q_item.word;
                        end
                        OP_WR_K:
                        begin
                            if (q_item.index < 10'(MAX_KEY_BYTES))
                            begin
                                k_we    = 1'b1;
                                k_waddr = KW'(q_item.index);
                                k_wdata = q_item.key_byte;
                            end
                        end
                        OP_EXPAND:
                        begin
                            len_next   = eff_len;
                            j_next     = '0;
                            n_next     = '0;
                            state_next = ST_KEYMIX;
                        end
                        OP_ENC, OP_DEC:
                        begin
                            dec_next   = (q_item.op == OP_DEC);
                            exp_next   = 1'b0;
                            p_rd_idx   = (q_item.op == OP_DEC) ? PIW'(ROUNDS + 1) : '0;
                            lx_next    = q_item.left_half ^ p_sel;
                            r_next     = q_item.right_half;
                            rnd_next   = '0;
                            state_next = ST_ROUND;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_KEYMIX:
            begin
                // Key bytes are read one per cycle and packed four to a P word.
                p_rd_idx = PIW'(kn_reg >> 2);
                if (n_reg < NW'(NTOT))
                begin
                    kv_next = 1'b1;
                    kn_next = n_reg;
                    n_next  = n_reg + 1'b1;
                    j_next  = ((KEY_LEN_W'(j_reg) + KEY_LEN_W'(1)) >= len_reg) ? '0
                                                                          : j_reg + 1'b1;
                end
                if (kv_reg)
                begin
                    acc_next = {acc_reg[15:0], k_rdata};
                    if (kn_reg[1:0] == 2'b11)
                    begin
                        p_we0  = 1'b1;
                        p_idx0 = PIW'(kn_reg >> 2);
                        p_d0   = p_sel ^ {acc_reg, k_rdata};
                    end
                    if (kn_reg == NW'(NTOT - 1))
                    begin
                        hold_l_next = '0;
                        hold_r_next = '0;
                        blk_next    = '0;
                        state_next  = ST_START;
                    end
                end
            end

            ST_START:
            begin
                p_rd_idx   = '0;
                lx_next    = hold_l_reg ^ p_sel;
                r_next     = hold_r_reg;
                rnd_next   = '0;
                dec_next   = 1'b0;
                exp_next   = 1'b1;
                state_next = ST_ROUND;
            end

            ST_ROUND:
            begin
                if (rnd_reg != RW'(ROUNDS - 1))
                begin
                    p_rd_idx = p_index(PIW'(rnd_reg) + PIW'(1), dec_reg);
                    lx_next  = new_l ^ p_sel;
                    r_next   = lx_reg;
                    rnd_next = rnd_reg + 1'b1;
                end
                else if (!exp_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_l_next     = res_l;
                        out_r_next     = res_r;
                        out_kind_next  = dec_reg ? KIND_DEC : KIND_ENC;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    hold_l_next = res_l;
                    hold_r_next = res_r;
                    if (blk_reg < BW'(P_BLOCKS))
                    begin
                        p_we0      = 1'b1;
                        p_idx0     = PIW'({blk_reg, 1'b0});
                        p_d0       = res_l;
                        p_we1      = 1'b1;
                        p_idx1     = PIW'({blk_reg, 1'b1});
                        p_d1       = res_r;
                        blk_next   = blk_reg + 1'b1;
                        state_next = ST_START;
                    end
                    else
                    begin
                        state_next = ST_SW0;
                    end
                end
            end

            ST_SW0:
            begin
                s_we[s_pair[8:7]] = 1'b1;
                s_waddr    = {s_pair[6:0], 1'b0};
                s_wdata    = hold_l_reg;
                state_next = ST_SW1;
            end

            ST_SW1:
            begin
                s_we[s_pair[8:7]] = 1'b1;
                s_waddr = {s_pair[6:0], 1'b1};
                s_wdata = hold_r_reg;
                if (blk_reg == BW'(BLKS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    blk_next   = blk_reg + 1'b1;
                    state_next = ST_START;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_l_next     = '0;
                    out_r_next     = '0;
                    out_kind_next  = KIND_EXP;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            key_length_reg <= KEY_LEN_RESET;
            kv_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_l_reg      <= '0;
            out_r_reg      <= '0;
            out_kind_reg   <= KIND_ENC;
        end
        else
        begin
            state_reg     <= state_next;
            kv_reg        <= kv_next;
            out_valid_reg <= out_valid_next;
            out_l_reg     <= out_l_next;
            out_r_reg     <= out_r_next;
            out_kind_reg  <= out_kind_next;
            if (cfg_we)
            begin
                key_length_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lx_reg     <= lx_next;
        r_reg      <= r_next;
        hold_l_reg <= hold_l_next;
        hold_r_reg <= hold_r_next;
        rnd_reg    <= rnd_next;
        dec_reg    <= dec_next;
        exp_reg    <= exp_next;
        blk_reg    <= blk_next;
        n_reg      <= n_next;
        kn_reg     <= kn_next;
        j_reg      <= j_next;
        acc_reg    <= acc_next;
        len_reg    <= len_next;
        if (p_we0)
        begin
            p_reg[p_idx0] <= p_d0;
        end
        if (p_we1)
        begin
            p_reg[p_idx1] <= p_d1;
        end
    end

    assign res_ch.valid       = out_valid_reg;
    assign res_ch.out_left    = out_l_reg;
    assign res_ch.out_right   = out_r_reg;
    assign res_ch.result_kind = out_kind_reg;

endmodule

`default_nettype wire
